### hdl/wpsp_pkg.sv
// Shared types and constants for the world point screen projection block.
// No dependencies; every other file imports this package.
package wpsp_pkg;

   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;
   localparam int COORD_IN_W = 32;
   localparam int DIM_W     = 14;
   localparam int COORD_W   = 30;
   localparam int DEPTH_W   = 18;
   localparam int OUTCOME_W = 2;

   localparam logic [OUTCOME_W-1:0] OUT_VISIBLE = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_BEHIND  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_OUTSIDE = 2'd2;

   typedef struct packed {
      logic signed [COORD_IN_W-1:0] world_x;
      logic signed [COORD_IN_W-1:0] world_y;
      logic signed [COORD_IN_W-1:0] world_z;
      logic [DIM_W-1:0]             screen_width;
      logic [DIM_W-1:0]             screen_height;
   } wpsp_req_type;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [COORD_W-1:0]   screen_x;
      logic [COORD_W-1:0]   screen_y;
      logic [DEPTH_W-1:0]   depth;
   } wpsp_rsp_type;

endpackage

### hdl/wpsp_clip.sv
// Matrix times point: three stages (multiply, truncate, sum) giving clip x, y, z, w.
// Depends on wpsp_pkg.
module wpsp_clip #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              adv,
   input  logic                                              in_valid,
   input  wpsp_pkg::wpsp_req_type                            in_data,
   input  logic [wpsp_pkg::NUM_REGS-1:0][wpsp_pkg::CSR_DAT_W-1:0] matrix,
   output logic                                              out_valid,
   output logic [3:0][65-FRAC_BITS-1:0]                      out_clip,
   output logic [wpsp_pkg::DIM_W-1:0]                        out_width,
   output logic [wpsp_pkg::DIM_W-1:0]                        out_height
);
   import wpsp_pkg::*;

   localparam int CW = 65 - FRAC_BITS;
   localparam int PW = 64;
   localparam logic [PW-1:0] BIAS = (PW'(1) << FRAC_BITS) - PW'(1);

   logic               valid_ff [3];
   logic [DIM_W-1:0]   wdt_ff [3];
   logic [DIM_W-1:0]   hgt_ff [3];

   logic signed [COORD_IN_W-1:0] pt [3];
   logic signed [PW-1:0] prod_in [4][3];
   logic signed [PW-1:0] prod_ff [4][3];
   logic signed [COORD_IN_W-1:0] ofs_in [4];
   logic signed [COORD_IN_W-1:0] ofs_ff [4];
   logic signed [PW-1:0] biased [4][3];
   logic signed [PW-1:0] shifted [4][3];
   logic signed [CW-1:0] trunc_in [4][4];
   logic signed [CW-1:0] trunc_ff [4][4];
   logic signed [CW-1:0] sum_in [4];
   logic signed [CW-1:0] sum_ff [4];

   assign pt[0] = in_data.world_x;
   assign pt[1] = in_data.world_y;
   assign pt[2] = in_data.world_z;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(matrix[r*2 + c/2][(c%2)*32 +: 32]) * pt[c];
         end
         ofs_in[r] = $signed(matrix[r*2 + 1][63:32]);
      end
   end

   // truncate toward zero: bias negative products before the arithmetic shift
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            biased[r][c]   = prod_ff[r][c] + $signed(prod_ff[r][c][PW-1] ? BIAS : '0);
            shifted[r][c]  = biased[r][c] >>> FRAC_BITS;
            trunc_in[r][c] = shifted[r][c][CW-1:0];
         end
         trunc_in[r][3] = CW'(ofs_ff[r]);
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum_in[r] = trunc_ff[r][0] + trunc_ff[r][1] + trunc_ff[r][2] + trunc_ff[r][3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 3; s++) valid_ff[s] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         valid_ff[1] <= valid_ff[0];
         valid_ff[2] <= valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff  <= prod_in;
         ofs_ff   <= ofs_in;
         trunc_ff <= trunc_in;
         sum_ff   <= sum_in;
         wdt_ff[0] <= in_data.screen_width;
         hgt_ff[0] <= in_data.screen_height;
         for (int s = 1; s < 3; s++) begin
            wdt_ff[s] <= wdt_ff[s-1];
            hgt_ff[s] <= hgt_ff[s-1];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) out_clip[r] = sum_ff[r];
   end
   assign out_valid  = valid_ff[2];
   assign out_width  = wdt_ff[2];
   assign out_height = hgt_ff[2];

endmodule

### hdl/wpsp_div.sv
// Pipelined floor(t * a / d): one bit of t per stage, remainder kept below d.
// Depends on wpsp_pkg.
module wpsp_div #(
   parameter int T_BITS = 30,
   parameter int DW     = 50
) (
   input  logic              clock,
   input  logic              adv,
   input  logic [T_BITS-1:0] t,
   input  logic [DW-1:0]     a,
   input  logic [DW-1:0]     d,
   output logic [T_BITS-1:0] q
);
   import wpsp_pkg::*;

   localparam int RW = DW + 1;

   logic [DW-1:0]     r_ff [T_BITS];
   logic [DW-1:0]     a_ff [T_BITS];
   logic [DW-1:0]     d_ff [T_BITS];
   logic [T_BITS-1:0] t_ff [T_BITS];
   logic [T_BITS-1:0] q_ff [T_BITS];

   for (genvar k = 0; k < T_BITS; k++) begin : g_step
      logic [DW-1:0]     r_prev, a_prev, d_prev, r_next;
      logic [T_BITS-1:0] t_prev, q_prev, q_next;
      logic [RW-1:0]     r2, d1x, d2x;

      if (k == 0) begin : g_first
         assign r_prev = '0;
         assign q_prev = '0;
         assign a_prev = a;
         assign d_prev = d;
         assign t_prev = t;
      end else begin : g_next
         assign r_prev = r_ff[k-1];
         assign q_prev = q_ff[k-1];
         assign a_prev = a_ff[k-1];
         assign d_prev = d_ff[k-1];
         assign t_prev = t_ff[k-1];
      end

      always_comb begin
         r2  = (RW'(r_prev) << 1) + (t_prev[T_BITS-1-k] ? RW'(a_prev) : '0);
         d1x = RW'(d_prev);
         d2x = d1x << 1;
         q_next = q_prev << 1;
         r_next = r2[DW-1:0];
         if (r2 >= d2x) begin
            r_next = DW'(r2 - d2x);
            q_next = (q_prev << 1) + T_BITS'(2);
         end else if (r2 >= d1x) begin
            r_next = DW'(r2 - d1x);
            q_next = (q_prev << 1) + T_BITS'(1);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[k] <= r_next;
            q_ff[k] <= q_next;
            a_ff[k] <= a_prev;
            d_ff[k] <= d_prev;
            t_ff[k] <= t_prev;
         end
      end
   end

   assign q = q_ff[T_BITS-1];

endmodule

### hdl/world_point_screen_projection.sv
// Top level of the world point screen projection: matrix registers, classify stage,
// three division pipelines and the output register with skid. Depends on wpsp_pkg,
// wpsp_clip and wpsp_div.
//
//   channel | ports                                 | direction | word
//   --------+---------------------------------------+-----------+--------------------------
//   request | req_valid, req_ready, req_data        | in        | world point + screen size
//   result  | rsp_valid, rsp_ready, rsp_data        | out       | outcome, pixel x/y, depth
//   config  | csr_valid, csr_ready, csr_index/data  | in        | one 64-bit matrix register
//
// One word enters per cycle while the skid register is empty; each word passes through
// three matrix stages, one classify stage, FRAC_BITS + 14 divider stages (one quotient
// bit of the pixel/depth division each) and the output register.
// Reset loads the identity matrix and empties the pipeline; the block takes words in the
// cycle after reset. A stalled result parks in the skid register, which then freezes the
// whole pipeline for as long as it is full; nothing is dropped or repeated.
module world_point_screen_projection #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wpsp_pkg::wpsp_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wpsp_pkg::wpsp_rsp_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wpsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wpsp_pkg::CSR_DAT_W-1:0]      csr_data
);
   import wpsp_pkg::*;

   localparam int CW     = 65 - FRAC_BITS;   // clip value width, signed
   localparam int DW     = 66 - FRAC_BITS;   // divider operand width
   localparam int T_BITS = DIM_W + FRAC_BITS;
   localparam int NSTEP  = T_BITS;
   localparam int CMP_W  = (T_BITS > COORD_W) ? T_BITS : COORD_W;
   localparam logic [CMP_W-1:0] LIM  = CMP_W'(8192) << FRAC_BITS;
   localparam logic [CMP_W-1:0] CMAX = CMP_W'({COORD_W{1'b1}});
   localparam logic [T_BITS:0]  TWO  = (T_BITS+1)'(2) << FRAC_BITS;
   localparam logic [DEPTH_W-1:0] DEPTH_HIDDEN = TWO[DEPTH_W-1:0];
   localparam logic [CSR_DAT_W-1:0] ONE_LO = CSR_DAT_W'(1) << FRAC_BITS;
   localparam logic [CSR_DAT_W-1:0] ONE_HI = CSR_DAT_W'(1) << (32 + FRAC_BITS);
   localparam logic [NUM_REGS-1:0][CSR_DAT_W-1:0] MATRIX_RESET =
      {ONE_HI, CSR_DAT_W'(0), ONE_LO, CSR_DAT_W'(0),
       CSR_DAT_W'(0), ONE_HI, CSR_DAT_W'(0), ONE_LO};

   logic [NUM_REGS-1:0][CSR_DAT_W-1:0] matrix_ff;
   logic adv;

   // configuration: always ready, identity after reset
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= MATRIX_RESET;
      end else if (csr_valid) begin
         matrix_ff[csr_index] <= csr_data;
      end
   end

   // clip coordinates
   logic                       clip_valid;
   logic [3:0][CW-1:0]         clip;
   logic [DIM_W-1:0]           clip_wdt, clip_hgt;

   wpsp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_valid & req_ready),
      .in_data    (req_data),
      .matrix     (matrix_ff),
      .out_valid  (clip_valid),
      .out_clip   (clip),
      .out_width  (clip_wdt),
      .out_height (clip_hgt)
   );

   // classify and form divider operands
   logic signed [CW-1:0] cx, cy, cz, cw, ncw;
   logic [OUTCOME_W-1:0] outcome_in;
   logic [CW-1:0]        sum_x, dif_y, dbl_w;

   always_comb begin
      cx  = $signed(clip[0]);
      cy  = $signed(clip[1]);
      cz  = $signed(clip[2]);
      cw  = $signed(clip[3]);
      ncw = -cw;
      if (cw <= 0) begin
         outcome_in = OUT_BEHIND;
      end else if (cx < ncw || cx > cw || cy < ncw || cy > cw || cz < 0 || cz > cw) begin
         outcome_in = OUT_OUTSIDE;
      end else begin
         outcome_in = OUT_VISIBLE;
      end
      sum_x = cx + cw;
      dif_y = cw - cy;
      dbl_w = cw <<< 1;
   end

   logic [DW-1:0]     ax_ff, ay_ff, d2_ff, az_ff, dz_ff;
   logic [T_BITS-1:0] tx_ff, ty_ff, tz_ff;
   logic              meta_v_ff [NSTEP+1];
   logic [OUTCOME_W-1:0] meta_o_ff [NSTEP+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff <= DW'(sum_x);
         ay_ff <= DW'(dif_y);
         d2_ff <= DW'(dbl_w);
         az_ff <= DW'(cz);
         dz_ff <= DW'(cw);
         tx_ff <= T_BITS'(clip_wdt) << FRAC_BITS;
         ty_ff <= T_BITS'(clip_hgt) << FRAC_BITS;
         tz_ff <= T_BITS'(1) << FRAC_BITS;
         meta_o_ff[0] <= outcome_in;
         for (int s = 1; s <= NSTEP; s++) meta_o_ff[s] <= meta_o_ff[s-1];
      end
   end

   // valid bits ride alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NSTEP; s++) meta_v_ff[s] <= 1'b0;
      end else if (adv) begin
         meta_v_ff[0] <= clip_valid;
         for (int s = 1; s <= NSTEP; s++) meta_v_ff[s] <= meta_v_ff[s-1];
      end
   end

   logic [T_BITS-1:0] qx, qy, qz;

   wpsp_div #(.T_BITS(T_BITS), .DW(DW)) u_div_x (
      .clock (clock), .adv (adv), .t (tx_ff), .a (ax_ff), .d (d2_ff), .q (qx)
   );
   wpsp_div #(.T_BITS(T_BITS), .DW(DW)) u_div_y (
      .clock (clock), .adv (adv), .t (ty_ff), .a (ay_ff), .d (d2_ff), .q (qy)
   );
   wpsp_div #(.T_BITS(T_BITS), .DW(DW)) u_div_z (
      .clock (clock), .adv (adv), .t (tz_ff), .a (az_ff), .d (dz_ff), .q (qz)
   );

   // saturate coordinates; hide fields of points that are not visible
   logic [CMP_W-1:0] qxe, qye;
   wpsp_rsp_type     res;

   always_comb begin
      qxe = CMP_W'(qx);
      qye = CMP_W'(qy);
      if (qxe > LIM)  qxe = LIM;
      if (qxe > CMAX) qxe = CMAX;
      if (qye > LIM)  qye = LIM;
      if (qye > CMAX) qye = CMAX;
      res.outcome = meta_o_ff[NSTEP];
      if (meta_o_ff[NSTEP] == OUT_VISIBLE) begin
         res.screen_x = qxe[COORD_W-1:0];
         res.screen_y = qye[COORD_W-1:0];
         res.depth    = qz[DEPTH_W-1:0];
      end else begin
         res.screen_x = '0;
         res.screen_y = '0;
         res.depth    = DEPTH_HIDDEN;
      end
   end

   // output register plus skid; a full skid holds the pipeline
   logic         rsp_valid_ff, skid_valid_ff;
   wpsp_rsp_type rsp_data_ff, skid_data_ff;

   assign adv       = ~skid_valid_ff;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            rsp_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (meta_v_ff[NSTEP]) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_data_ff  <= res;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= res;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hdl/wpsp_check.sv
// Port-level checks for the world point screen projection, bound to the top level.
// Depends on wpsp_pkg and world_point_screen_projection.
module wpsp_check #(
   parameter int FRAC_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input wpsp_pkg::wpsp_rsp_type rsp_data
);
   import wpsp_pkg::*;

   localparam logic [FRAC_BITS+2:0] TWO = (FRAC_BITS+3)'(2) << FRAC_BITS;
   localparam logic [DEPTH_W-1:0] DEPTH_HIDDEN = DEPTH_W'(TWO);

   // hidden points carry zero coordinates and depth 2.0
   a_hidden_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome != OUT_VISIBLE |->
         rsp_data.screen_x == '0 && rsp_data.screen_y == '0 &&
         rsp_data.depth == DEPTH_HIDDEN)
      else $error("hidden point with nonzero fields");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // reset empties the pipeline and opens the request side
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state after reset wrong");

endmodule

bind world_point_screen_projection wpsp_check #(.FRAC_BITS(FRAC_BITS)) u_wpsp_check (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
